// ===== hw/rtl/sbc_pkg.sv =====
// Shared widths, command and status codes for the splitter bucket classifier.
`timescale 1ns / 1ps

package sbc_pkg;

   localparam int MAX_PIVOTS_DEF = 63;
   localparam int COUNT_BITS_DEF = 24;

   localparam int KEY_W       = 32;
   localparam int CMD_W       = 2;
   localparam int BUCKET_W    = 6;
   localparam int COUNT_OUT_W = 24;
   localparam int STATUS_W    = 2;

   localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLASSIFY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SAT  = 2'd2;

endpackage

// ===== hw/rtl/sbc_ram.sv =====
// Single-clock RAM, one write and one registered read per cycle.
`timescale 1ns / 1ps

module sbc_ram #(
   parameter int WIDTH = sbc_pkg::KEY_W,
   parameter int DEPTH = sbc_pkg::MAX_PIVOTS_DEF,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/splitter_bucket_classifier.sv =====
// Splitter bucket classifier: sequencer, shared key comparator and result register.
// Insert moves each larger pivot up one slot and stops at a pivot that is not larger or at
// slot 0; classify runs a binary search (one pivot read per bound), then a read-modify-write
// of the bucket count; clear reruns the count-clearing pass; a full-table insert and an unused
// command are answered from idle. One item at a time. Reset (synchronous) empties the table and
// runs a count-clearing pass with busy high. Results cannot be stalled by the receiver.
`timescale 1ns / 1ps

module splitter_bucket_classifier #(
   parameter int MAX_PIVOTS = sbc_pkg::MAX_PIVOTS_DEF,
   parameter int COUNT_BITS = sbc_pkg::COUNT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [sbc_pkg::CMD_W-1:0]        req_command,
   input  logic [sbc_pkg::KEY_W-1:0]        req_key,
   output logic                             rsp_valid,
   output logic [sbc_pkg::BUCKET_W-1:0]     rsp_bucket,
   output logic [sbc_pkg::COUNT_OUT_W-1:0]  rsp_count_after,
   output logic [sbc_pkg::STATUS_W-1:0]     rsp_status
);

   import sbc_pkg::*;

   localparam int BW  = $clog2(MAX_PIVOTS + 1);
   localparam int HW  = $clog2(MAX_PIVOTS + 2);
   localparam int PAW = (MAX_PIVOTS > 1) ? $clog2(MAX_PIVOTS) : 1;

   typedef enum logic [9:0] {
      S_CLEAR   = 10'b0000000001,
      S_IDLE    = 10'b0000000010,
      S_INS_RD  = 10'b0000000100,
      S_INS_CMP = 10'b0000001000,
      S_CLS_MID = 10'b0000010000,
      S_CLS_UP  = 10'b0000100000,
      S_CLS_LO  = 10'b0001000000,
      S_CNT_RD  = 10'b0010000000,
      S_CNT_WR  = 10'b0100000000,
      S_UNUSED  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [BW-1:0]          loaded_ff, loaded_in;
   logic [BW-1:0]          j_ff, j_in;
   logic [BW-1:0]          k_ff, k_in;
   logic [HW-1:0]          lo_ff, lo_in;
   logic [HW-1:0]          hi_ff, hi_in;
   logic [BW-1:0]          clr_addr_ff, clr_addr_in;
   logic                   clr_rsp_ff, clr_rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BUCKET_W-1:0]    rsp_bucket_ff, rsp_bucket_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;

   logic                   piv_we;
   logic [PAW-1:0]         piv_waddr, piv_raddr;
   logic [KEY_W-1:0]       piv_wdata, piv_rdata;
   logic                   cnt_we;
   logic [BW-1:0]          cnt_waddr, cnt_raddr;
   logic [COUNT_BITS-1:0]  cnt_wdata, cnt_rdata;

   logic                   accept;
   logic                   key_lt, key_gt;
   logic [HW:0]            mid_sum;
   logic [BW-1:0]          k_mid;
   logic [BW-1:0]          loaded_p1;
   logic                   cnt_sat;
   logic [COUNT_BITS-1:0]  cnt_next;

   sbc_ram #(
      .WIDTH (KEY_W),
      .DEPTH (MAX_PIVOTS),
      .AW    (PAW)
   ) u_pivot_ram (
      .clock (clock),
      .we    (piv_we),
      .waddr (piv_waddr),
      .wdata (piv_wdata),
      .raddr (piv_raddr),
      .rdata (piv_rdata)
   );

   sbc_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (MAX_PIVOTS + 1),
      .AW    (BW)
   ) u_count_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_waddr),
      .wdata (cnt_wdata),
      .raddr (cnt_raddr),
      .rdata (cnt_rdata)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // shared comparator: held key against the pivot just read
   assign key_lt = key_ff < piv_rdata;
   assign key_gt = key_ff > piv_rdata;

   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign k_mid     = BW'(mid_sum >> 1);
   assign loaded_p1 = loaded_ff + BW'(1);
   assign cnt_sat   = &cnt_rdata;
   assign cnt_next  = cnt_sat ? cnt_rdata : cnt_rdata + COUNT_BITS'(1);

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      loaded_in     = loaded_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      clr_addr_in   = clr_addr_ff;
      clr_rsp_in    = clr_rsp_ff;
      rsp_valid_in  = 1'b0;
      rsp_bucket_in = rsp_bucket_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      piv_we        = 1'b0;
      piv_waddr     = '0;
      piv_wdata     = key_ff;
      piv_raddr     = '0;
      cnt_we        = 1'b0;
      cnt_waddr     = k_ff;
      cnt_wdata     = cnt_next;
      cnt_raddr     = k_ff;

      case (state_ff)
         S_CLEAR: begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_addr_ff;
            cnt_wdata = '0;
            if (clr_addr_ff == BW'(MAX_PIVOTS)) begin
               state_in = S_IDLE;
               if (clr_rsp_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_bucket_in = '0;
                  rsp_count_in  = '0;
                  rsp_status_in = ST_OK;
               end
            end else begin
               clr_addr_in = clr_addr_ff + BW'(1);
            end
         end
         S_IDLE: begin
            if (start) begin
               key_in = req_key;
               case (req_command)
                  CMD_INSERT: begin
                     if (loaded_ff == BW'(MAX_PIVOTS)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_bucket_in = '0;
                        rsp_count_in  = COUNT_OUT_W'(loaded_ff);
                        rsp_status_in = ST_FULL;
                     end else begin
                        j_in     = loaded_ff;
                        state_in = S_INS_RD;
                     end
                  end
                  CMD_CLASSIFY: begin
                     lo_in    = '0;
                     hi_in    = HW'(loaded_ff) + HW'(1);
                     state_in = S_CLS_MID;
                  end
                  CMD_CLEAR: begin
                     loaded_in   = '0;
                     clr_addr_in = '0;
                     clr_rsp_in  = 1'b1;
                     state_in    = S_CLEAR;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_bucket_in = '0;
                     rsp_count_in  = '0;
                     rsp_status_in = ST_OK;
                  end
               endcase
            end
         end
         S_INS_RD: begin
            if (j_ff == '0) begin
               piv_we        = 1'b1;
               piv_waddr     = '0;
               loaded_in     = loaded_p1;
               rsp_valid_in  = 1'b1;
               rsp_bucket_in = '0;
               rsp_count_in  = COUNT_OUT_W'(loaded_p1);
               rsp_status_in = ST_OK;
               state_in      = S_IDLE;
            end else begin
               piv_raddr = PAW'(j_ff - BW'(1));
               state_in  = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            piv_we    = 1'b1;
            piv_waddr = PAW'(j_ff);
            if (key_lt) begin
               // move the larger pivot up one slot and keep walking down
               piv_wdata = piv_rdata;
               j_in      = j_ff - BW'(1);
               state_in  = S_INS_RD;
            end else begin
               loaded_in     = loaded_p1;
               rsp_valid_in  = 1'b1;
               rsp_bucket_in = BUCKET_W'(j_ff);
               rsp_count_in  = COUNT_OUT_W'(loaded_p1);
               rsp_status_in = ST_OK;
               state_in      = S_IDLE;
            end
         end
         S_CLS_MID: begin
            if (lo_ff >= hi_ff) begin
               k_in     = '0;
               state_in = S_CNT_RD;
            end else begin
               k_in = k_mid;
               if (k_mid < loaded_ff) begin
                  piv_raddr = PAW'(k_mid);
               end
               state_in = S_CLS_UP;
            end
         end
         S_CLS_UP: begin
            // upper bound is the all-ones sentinel past the last pivot
            if ((k_ff < loaded_ff) && key_gt) begin
               lo_in    = HW'(k_ff) + HW'(1);
               state_in = S_CLS_MID;
            end else if (k_ff == '0) begin
               state_in = S_CNT_RD;
            end else begin
               piv_raddr = PAW'(k_ff - BW'(1));
               state_in  = S_CLS_LO;
            end
         end
         S_CLS_LO: begin
            if (key_lt) begin
               hi_in    = HW'(k_ff);
               state_in = S_CLS_MID;
            end else begin
               state_in = S_CNT_RD;
            end
         end
         S_CNT_RD: begin
            state_in = S_CNT_WR;
         end
         S_CNT_WR: begin
            cnt_we        = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_bucket_in = BUCKET_W'(k_ff);
            rsp_count_in  = COUNT_OUT_W'(cnt_next);
            rsp_status_in = cnt_sat ? ST_SAT : ST_OK;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         loaded_ff    <= '0;
         clr_addr_ff  <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         clr_addr_ff  <= clr_addr_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      j_ff          <= j_in;
      k_ff          <= k_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      rsp_bucket_ff <= rsp_bucket_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bucket      = rsp_bucket_ff;
   assign rsp_count_after = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

`ifndef SYNTHESIS
   a_loaded_bound: assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= BW'(MAX_PIVOTS))
      else $error("pivot count above table depth");

   a_search_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLS_UP) |-> (lo_ff < hi_ff) && (hi_ff <= HW'(loaded_ff) + HW'(1)))
      else $error("binary search range out of order");

   a_shift_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_CMP) |-> (j_ff != '0) && (j_ff <= loaded_ff))
      else $error("insert shift index out of range");

   a_insert_start: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_command == CMD_INSERT) && (loaded_ff != BW'(MAX_PIVOTS)))
      |=> (state_ff == S_INS_RD) && (j_ff == $past(loaded_ff)))
      else $error("insert did not start at the table end");

   a_clear_silent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) && (clr_addr_ff != BW'(MAX_PIVOTS)) |=> !rsp_valid_ff)
      else $error("result given during clearing pass");
`endif

endmodule

// ===== test/sbc_checker.sv =====
// Result checker for the splitter bucket classifier: predicts each item's result and compares.
`timescale 1ns / 1ps

module sbc_checker #(
   parameter int MAX_PIVOTS = sbc_pkg::MAX_PIVOTS_DEF,
   parameter int COUNT_BITS = sbc_pkg::COUNT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic [sbc_pkg::CMD_W-1:0]        req_command,
   input  logic [sbc_pkg::KEY_W-1:0]        req_key,
   input  logic                             rsp_valid,
   input  logic [sbc_pkg::BUCKET_W-1:0]     rsp_bucket,
   input  logic [sbc_pkg::COUNT_OUT_W-1:0]  rsp_count_after,
   input  logic [sbc_pkg::STATUS_W-1:0]     rsp_status,
   output int                               fail_count,
   output int                               pending,
   output int                               result_count,
   output int                               full_count
);

   import sbc_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [BUCKET_W-1:0]    bucket;
      logic [COUNT_OUT_W-1:0] count_after;
      logic [STATUS_W-1:0]    status;
   } outcome_type;

   logic [KEY_W-1:0]      splitter_tbl [0:MAX_PIVOTS-1];
   int unsigned           splitters_held;
   logic [COUNT_BITS-1:0] bin_count [0:MAX_PIVOTS];
   outcome_type           awaited [$];
   outcome_type           want;

   task automatic report_mismatch(input string what, input longint got, input longint exp);
      $display("MISMATCH at %0t: %s: got %0d, expected %0d", $realtime, what, got, exp);
      fail_count++;
   endtask

   // Table boundary with the zero sentinel below and the all-ones sentinel above.
   function automatic logic [KEY_W-1:0] bound_at(input int unsigned i);
      if (i == 0)
         return '0;
      if (i > splitters_held || i > MAX_PIVOTS)
         return '1;
      return splitter_tbl[i-1];
   endfunction

   function automatic int unsigned find_bucket(input logic [KEY_W-1:0] v);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      int unsigned steps;
      lo = 0;
      hi = splitters_held + 1;
      steps = 0;
      while (lo < hi && steps < 2 * MAX_PIVOTS + 8) begin
         mid = (lo + hi) >> 1;
         steps++;
         if (v > bound_at(mid + 1))
            lo = mid + 1;
         else if (v < bound_at(mid))
            hi = mid;
         else
            return mid;
      end
      return 0;
   endfunction

   function automatic outcome_type predict_outcome(input logic [CMD_W-1:0] cmd,
                                                   input logic [KEY_W-1:0] key);
      outcome_type res;
      int unsigned slot;
      res = '0;
      case (cmd)
         CMD_INSERT: begin
            if (splitters_held >= MAX_PIVOTS) begin
               res.status      = ST_FULL;
               res.count_after = COUNT_OUT_W'(splitters_held);
            end else begin
               // shift larger splitters up; an equal key lands after its peers
               slot = splitters_held;
               while (slot > 0 && key < splitter_tbl[slot-1]) begin
                  splitter_tbl[slot] = splitter_tbl[slot-1];
                  slot--;
               end
               splitter_tbl[slot] = key;
               splitters_held++;
               res.bucket      = BUCKET_W'(slot);
               res.count_after = COUNT_OUT_W'(splitters_held);
            end
         end
         CMD_CLASSIFY: begin
            slot = find_bucket(key);
            if (slot > MAX_PIVOTS)
               slot = MAX_PIVOTS;
            if (bin_count[slot] == COUNT_MAX)
               res.status = ST_SAT;
            else
               bin_count[slot]++;
            res.bucket      = BUCKET_W'(slot);
            res.count_after = COUNT_OUT_W'(bin_count[slot]);
         end
         CMD_CLEAR: begin
            foreach (bin_count[i])
               bin_count[i] = '0;
            splitters_held = 0;
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         splitters_held = 0;
         foreach (bin_count[i])
            bin_count[i] = '0;
         awaited.delete();
         fail_count   = 0;
         result_count = 0;
         full_count   = 0;
      end else begin
         // the result leaving at this edge belongs to an earlier item
         if (rsp_valid) begin
            result_count++;
            if (awaited.size() == 0) begin
               report_mismatch("result with no item outstanding, bucket", rsp_bucket, 0);
            end else begin
               want = awaited.pop_front();
               if (want.status == ST_FULL)
                  full_count++;
               if (rsp_bucket !== want.bucket)
                  report_mismatch("bucket", rsp_bucket, want.bucket);
               if (rsp_count_after !== want.count_after)
                  report_mismatch("count_after", rsp_count_after, want.count_after);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
            end
         end
         if (start && !busy)
            awaited.push_back(predict_outcome(req_command, req_key));
      end
      pending = awaited.size();
   end

endmodule

// ===== test/splitter_bucket_classifier_test.sv =====
// Top of the splitter bucket classifier testbench: clock, reset, item stimulus and verdict.
`timescale 1ns / 1ps

module splitter_bucket_classifier_test;

   import sbc_pkg::*;

   localparam int RANDOM_ITEMS = 500;
   localparam int STALL_LIMIT  = 4000;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [CMD_W-1:0]       req_command;
   logic [KEY_W-1:0]       req_key;
   logic                   rsp_valid;
   logic [BUCKET_W-1:0]    rsp_bucket;
   logic [COUNT_OUT_W-1:0] rsp_count_after;
   logic [STATUS_W-1:0]    rsp_status;

   int fail_count;
   int pending;
   int result_count;
   int full_count;
   int idle_cycles = 0;
   int sent = 0;
   int directed_n;
   int n_inserts;
   bit quiet = 1'b0;
   bit first_fill;

   logic [KEY_W-1:0] splitters [$];

   splitter_bucket_classifier u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_bucket      (rsp_bucket),
      .rsp_count_after (rsp_count_after),
      .rsp_status      (rsp_status)
   );

   sbc_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_bucket      (rsp_bucket),
      .rsp_count_after (rsp_count_after),
      .rsp_status      (rsp_status),
      .fail_count      (fail_count),
      .pending         (pending),
      .result_count    (result_count),
      .full_count      (full_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // End the run when neither side has moved for too long.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   function automatic logic [KEY_W-1:0] pick_splitter();
      int r;
      r = $urandom_range(0, 9);
      if (r < 2 && splitters.size() != 0)
         return splitters[$urandom_range(0, splitters.size() - 1)];
      case (r)
         2: return '0;
         3: return '1;
         4: return KEY_W'($urandom_range(0, 15));
         default: return $urandom();
      endcase
   endfunction

   // Aim keys at splitters and their neighbors so ties and edges get hit.
   function automatic logic [KEY_W-1:0] pick_probe();
      logic [KEY_W-1:0] p;
      int r;
      r = $urandom_range(0, 9);
      if (splitters.size() == 0 || r < 2)
         return $urandom();
      p = splitters[$urandom_range(0, splitters.size() - 1)];
      case (r)
         2, 3, 4: return p;
         5: return p + 1;
         6: return p - 1;
         7: return '0;
         8: return '1;
         default: return $urandom();
      endcase
   endfunction

   task automatic send(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key);
      int gap;
      start       <= 1'b1;
      req_command <= cmd;
      req_key     <= key;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      @(negedge clock);
      sent++;
      if (cmd == CMD_INSERT && splitters.size() < u_dut.MAX_PIVOTS)
         splitters.push_back(key);
      else if (cmd == CMD_CLEAR)
         splitters.delete();
      gap = pick_gap();
      if (gap > 0) begin
         // drop start and scramble the payload so an idle item is ignored
         start       <= 1'b0;
         req_command <= CMD_W'($urandom_range(0, 3));
         req_key     <= $urandom();
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_mixed(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key);
      if ($urandom_range(0, 19) == 0)
         send(CMD_W'($urandom_range(0, 3)), $urandom());
      else
         send(cmd, key);
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_command = CMD_INSERT;
      req_key     = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty table, sentinels, ties, unused command, clear
      send(CMD_UNUSED, $urandom());
      send(CMD_CLASSIFY, 32'h0000_0000);
      send(CMD_CLASSIFY, 32'hFFFF_FFFF);
      send(CMD_INSERT, 32'h8000_0000);
      send(CMD_INSERT, 32'h0000_0000);
      send(CMD_INSERT, 32'hFFFF_FFFF);
      send(CMD_INSERT, 32'h8000_0000);
      send(CMD_INSERT, 32'h8000_0000);
      send(CMD_CLASSIFY, 32'h0000_0000);
      send(CMD_CLASSIFY, 32'hFFFF_FFFF);
      send(CMD_CLASSIFY, 32'h8000_0000);
      send(CMD_CLASSIFY, 32'h7FFF_FFFF);
      send(CMD_CLASSIFY, 32'h8000_0001);
      send(CMD_CLASSIFY, 32'hFFFF_FFFE);
      send(CMD_CLASSIFY, 32'h0000_0001);
      send(CMD_CLASSIFY, 32'h8000_0000);
      send(CMD_CLEAR, 32'hFFFF_FFFF);
      send(CMD_CLASSIFY, 32'h0000_0005);
      send(CMD_UNUSED, 32'hFFFF_FFFF);
      send(CMD_INSERT, 32'h5555_5555);
      send(CMD_INSERT, 32'hAAAA_AAAA);
      send(CMD_CLASSIFY, 32'hAAAA_AAAA);
      send(CMD_CLASSIFY, 32'h5555_5555);
      directed_n = sent;

      // random: fill the table to some depth, then classify against it
      first_fill = 1'b1;
      while (sent < directed_n + RANDOM_ITEMS) begin
         quiet = ($urandom_range(0, 4) == 0);
         if (first_fill || $urandom_range(0, 3) != 0)
            send(CMD_CLEAR, $urandom());
         if (first_fill || $urandom_range(0, 4) == 0)
            n_inserts = u_dut.MAX_PIVOTS + $urandom_range(1, 3);
         else
            n_inserts = $urandom_range(1, 20);
         first_fill = 1'b0;
         repeat (n_inserts) send_mixed(CMD_INSERT, pick_splitter());
         repeat ($urandom_range(8, 30)) send_mixed(CMD_CLASSIFY, pick_probe());
      end
      quiet = 1'b0;
      start <= 1'b0;

      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Sent %0d items (%0d directed) with inserts, classifies, clears and unused codes;",
               sent, directed_n);
      $display("checked %0d results, %0d of them inserts refused by a full table.",
               result_count, full_count);
      if (fail_count == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/sbc_pkg.sv
hw/rtl/sbc_ram.sv
hw/rtl/splitter_bucket_classifier.sv
test/sbc_checker.sv
test/splitter_bucket_classifier_test.sv
